// ----- design/sis_pkg.sv -----
`default_nettype none

package sis_pkg;

   localparam int COORD_BITS = 32;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

endpackage

`default_nettype wire

// ----- design/sis_cross.sv -----
`default_nettype none

module sis_cross (
   input  wire                    clock,
   input  wire                    enable,
   input  wire sis_pkg::diff_type ux,
   input  wire sis_pkg::diff_type uy,
   input  wire sis_pkg::diff_type vx,
   input  wire sis_pkg::diff_type vy,
   output sis_pkg::sign_type      sign
);
   import sis_pkg::*;

   prod_type p_ff, p_in;
   prod_type q_ff, q_in;
   sign_type sign_ff, sign_in;

   assign p_in = prod_type'(ux) * prod_type'(vy);
   assign q_in = prod_type'(uy) * prod_type'(vx);

   always_comb begin
      sign_in.pos = p_ff > q_ff;
      sign_in.neg = p_ff < q_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

`default_nettype wire

// ----- design/segment_intersection_test.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_a_start_x .. req_b_end_y (signed)
// rsp       out        rsp_valid / rsp_ready  rsp_intersects
//
// One item per cycle while no result waits; a request passes the stages below in order.
// Stages: differences and bounds, products and bound compares,
// product compares, decision into the output register.
// The whole pipeline holds while a result waits; req_ready follows that hold.
// Synchronous reset clears the valid bits only.
`default_nettype none

module segment_intersection_test (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire sis_pkg::coord_type req_a_start_x,
   input  wire sis_pkg::coord_type req_a_start_y,
   input  wire sis_pkg::coord_type req_a_end_x,
   input  wire sis_pkg::coord_type req_a_end_y,
   input  wire sis_pkg::coord_type req_b_start_x,
   input  wire sis_pkg::coord_type req_b_start_y,
   input  wire sis_pkg::coord_type req_b_end_x,
   input  wire sis_pkg::coord_type req_b_end_y,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic                    rsp_intersects
);
   import sis_pkg::*;

   logic advance;

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   diff_type d21x_ff, d21y_ff, d43x_ff, d43y_ff;
   diff_type d31x_ff, d31y_ff, d41x_ff, d41y_ff;
   diff_type d13x_ff, d13y_ff, d23x_ff, d23y_ff;
   coord_type a_max_x_ff, a_max_y_ff, a_min_x_ff, a_min_y_ff;
   coord_type b_max_x_ff, b_max_y_ff, b_min_x_ff, b_min_y_ff;
   logic a_below_ff, b_below_ff, a_below3_ff, b_below3_ff;
   logic rsp_intersects_ff, rsp_intersects_in;
   sign_type c0, c1, c2, c3, c4;
   logic side_a, side_b;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d21x_ff <= diff_type'(req_a_end_x) - diff_type'(req_a_start_x);
         d21y_ff <= diff_type'(req_a_end_y) - diff_type'(req_a_start_y);
         d43x_ff <= diff_type'(req_b_end_x) - diff_type'(req_b_start_x);
         d43y_ff <= diff_type'(req_b_end_y) - diff_type'(req_b_start_y);
         d31x_ff <= diff_type'(req_b_start_x) - diff_type'(req_a_start_x);
         d31y_ff <= diff_type'(req_b_start_y) - diff_type'(req_a_start_y);
         d41x_ff <= diff_type'(req_b_end_x) - diff_type'(req_a_start_x);
         d41y_ff <= diff_type'(req_b_end_y) - diff_type'(req_a_start_y);
         d13x_ff <= diff_type'(req_a_start_x) - diff_type'(req_b_start_x);
         d13y_ff <= diff_type'(req_a_start_y) - diff_type'(req_b_start_y);
         d23x_ff <= diff_type'(req_a_end_x) - diff_type'(req_b_start_x);
         d23y_ff <= diff_type'(req_a_end_y) - diff_type'(req_b_start_y);
         a_max_x_ff <= (req_a_start_x > req_a_end_x) ? req_a_start_x : req_a_end_x;
         a_min_x_ff <= (req_a_start_x < req_a_end_x) ? req_a_start_x : req_a_end_x;
         a_max_y_ff <= (req_a_start_y > req_a_end_y) ? req_a_start_y : req_a_end_y;
         a_min_y_ff <= (req_a_start_y < req_a_end_y) ? req_a_start_y : req_a_end_y;
         b_max_x_ff <= (req_b_start_x > req_b_end_x) ? req_b_start_x : req_b_end_x;
         b_min_x_ff <= (req_b_start_x < req_b_end_x) ? req_b_start_x : req_b_end_x;
         b_max_y_ff <= (req_b_start_y > req_b_end_y) ? req_b_start_y : req_b_end_y;
         b_min_y_ff <= (req_b_start_y < req_b_end_y) ? req_b_start_y : req_b_end_y;
         a_below_ff  <= (a_max_x_ff < b_min_x_ff) || (a_max_y_ff < b_min_y_ff);
         b_below_ff  <= (b_max_x_ff < a_min_x_ff) || (b_max_y_ff < a_min_y_ff);
         a_below3_ff <= a_below_ff;
         b_below3_ff <= b_below_ff;
         rsp_intersects_ff <= rsp_intersects_in;
      end
   end

   sis_cross u_cross0 (
      .clock(clock), .enable(advance),
      .ux(d43x_ff), .uy(d43y_ff), .vx(d21x_ff), .vy(d21y_ff), .sign(c0)
   );
   sis_cross u_cross1 (
      .clock(clock), .enable(advance),
      .ux(d21x_ff), .uy(d21y_ff), .vx(d31x_ff), .vy(d31y_ff), .sign(c1)
   );
   sis_cross u_cross2 (
      .clock(clock), .enable(advance),
      .ux(d21x_ff), .uy(d21y_ff), .vx(d41x_ff), .vy(d41y_ff), .sign(c2)
   );
   sis_cross u_cross3 (
      .clock(clock), .enable(advance),
      .ux(d43x_ff), .uy(d43y_ff), .vx(d13x_ff), .vy(d13y_ff), .sign(c3)
   );
   sis_cross u_cross4 (
      .clock(clock), .enable(advance),
      .ux(d43x_ff), .uy(d43y_ff), .vx(d23x_ff), .vy(d23y_ff), .sign(c4)
   );

   assign side_a = (c1.neg && c2.neg) || (c1.pos && c2.pos);
   assign side_b = (c3.neg && c4.neg) || (c3.pos && c4.pos);

   always_comb begin
      if (!c0.pos && !c0.neg) begin
         rsp_intersects_in = !c1.pos && !c1.neg && !a_below3_ff && !b_below3_ff;
      end else begin
         rsp_intersects_in = !side_a && !side_b;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_intersects = rsp_intersects_ff;

endmodule

`default_nettype wire

// ----- tb/segment_intersection_checker.sv -----
`timescale 1ns / 100ps

module segment_intersection_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  sis_pkg::coord_type req_a_start_x,
   input  sis_pkg::coord_type req_a_start_y,
   input  sis_pkg::coord_type req_a_end_x,
   input  sis_pkg::coord_type req_a_end_y,
   input  sis_pkg::coord_type req_b_start_x,
   input  sis_pkg::coord_type req_b_start_y,
   input  sis_pkg::coord_type req_b_end_x,
   input  sis_pkg::coord_type req_b_end_y,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  wire                rsp_intersects,
   output int                 fail_count,
   output int                 outstanding
);

   bit expected_meet_q[$];

   // exact sign of ux*vy - uy*vx
   function automatic int cross_dir(longint ux, longint uy, longint vx, longint vy);
      logic signed [127:0] a, b, c, d, lhs, rhs;
      a = ux;
      b = uy;
      c = vx;
      d = vy;
      lhs = a * d;
      rhs = b * c;
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic bit straddle_fails(longint px, longint py, longint qx, longint qy,
                                         longint rx, longint ry, longint sx, longint sy);
      int s1, s2;
      s1 = cross_dir(qx - px, qy - py, rx - px, ry - py);
      s2 = cross_dir(qx - px, qy - py, sx - px, sy - py);
      return (s1 < 0 && s2 < 0) || (s1 > 0 && s2 > 0);
   endfunction

   function automatic bit lies_below(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry, longint sx, longint sy);
      longint hi_x, hi_y, lo_x, lo_y;
      hi_x = (px > qx) ? px : qx;
      hi_y = (py > qy) ? py : qy;
      lo_x = (rx < sx) ? rx : sx;
      lo_y = (ry < sy) ? ry : sy;
      return (hi_x < lo_x) || (hi_y < lo_y);
   endfunction

   function automatic bit predict_intersects(longint x1, longint y1, longint x2, longint y2,
                                             longint x3, longint y3, longint x4, longint y4);
      if (cross_dir(x4 - x3, y4 - y3, x2 - x1, y2 - y1) == 0) begin
         if (cross_dir(x2 - x1, y2 - y1, x3 - x1, y3 - y1) != 0) return 1'b0;
         return !lies_below(x1, y1, x2, y2, x3, y3, x4, y4) &&
                !lies_below(x3, y3, x4, y4, x1, y1, x2, y2);
      end
      return !straddle_fails(x1, y1, x2, y2, x3, y3, x4, y4) &&
             !straddle_fails(x3, y3, x4, y4, x1, y1, x2, y2);
   endfunction

   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_meet_q.push_back(predict_intersects(
               longint'(req_a_start_x), longint'(req_a_start_y),
               longint'(req_a_end_x),   longint'(req_a_end_y),
               longint'(req_b_start_x), longint'(req_b_start_y),
               longint'(req_b_end_x),   longint'(req_b_end_y)));
         if (rsp_valid && rsp_ready) begin
            if (expected_meet_q.size() == 0) begin
               $error("intersects: unexpected item, actual %0b", rsp_intersects);
               fail_count = fail_count + 1;
            end else begin
               want = expected_meet_q.pop_front();
               if (rsp_intersects !== want) begin
                  $error("intersects: expected %0b, actual %0b", want, rsp_intersects);
                  fail_count = fail_count + 1;
               end
            end
         end
         outstanding <= expected_meet_q.size();
      end
   end

endmodule

// ----- tb/segment_intersection_test_test.sv -----
`timescale 1ns / 100ps

module segment_intersection_test_test;

   import sis_pkg::*;

   localparam coord_type CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam int RANDOM_ITEMS = 1430;
   localparam int STUCK_LIMIT = 2000;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_a_start_x = '0;
   coord_type req_a_start_y = '0;
   coord_type req_a_end_x = '0;
   coord_type req_a_end_y = '0;
   coord_type req_b_start_x = '0;
   coord_type req_b_start_y = '0;
   coord_type req_b_end_x = '0;
   coord_type req_b_end_y = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_intersects;

   int fail_count;
   int outstanding;
   int stuck_cycles = 0;
   bit valid_held = 1'b0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;

   segment_intersection_test u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_start_x (req_a_start_x),
      .req_a_start_y (req_a_start_y),
      .req_a_end_x   (req_a_end_x),
      .req_a_end_y   (req_a_end_y),
      .req_b_start_x (req_b_start_x),
      .req_b_start_y (req_b_start_y),
      .req_b_end_x   (req_b_end_x),
      .req_b_end_y   (req_b_end_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_intersects(rsp_intersects)
   );

   segment_intersection_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_start_x (req_a_start_x),
      .req_a_start_y (req_a_start_y),
      .req_a_end_x   (req_a_end_x),
      .req_a_end_y   (req_a_end_y),
      .req_b_start_x (req_b_start_x),
      .req_b_start_y (req_b_start_y),
      .req_b_end_x   (req_b_end_x),
      .req_b_end_y   (req_b_end_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_intersects(rsp_intersects),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck_cycles = 0;
         else
            stuck_cycles = stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // result side: random stalls per item, with calm stretches
   initial begin
      int stall;
      int taken;
      taken = 0;
      @(negedge reset);
      forever begin
         if (taken % 50 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         stall = receiver_calm ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken = taken + 1;
      end
   end

   task automatic send_pair(input coord_type asx, input coord_type asy,
                            input coord_type aex, input coord_type aey,
                            input coord_type bsx, input coord_type bsy,
                            input coord_type bex, input coord_type bey);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         if (valid_held) begin
            req_valid <= 1'b0;
            valid_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      valid_held    = 1'b1;
      req_a_start_x <= asx;
      req_a_start_y <= asy;
      req_a_end_x   <= aex;
      req_a_end_y   <= aey;
      req_b_start_x <= bsx;
      req_b_start_y <= bsy;
      req_b_end_x   <= bex;
      req_b_end_y   <= bey;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic coord_type pick_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 16)) - 8);
         default: begin
            case ($urandom_range(0, 6))
               0: return CMIN;
               1: return CMAX;
               2: return CMIN + 1;
               3: return CMAX - 1;
               4: return '0;
               5: return '1;
               default: return coord_type'(1);
            endcase
         end
      endcase
   endfunction

   initial begin
      coord_type c [8];
      int kind;
      int base_x, base_y, dir_x, dir_y, off_x, off_y, k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes, degenerate segments, parallel, collinear, touching, straddle
      send_pair(0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
      send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
      send_pair(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN);
      send_pair(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
      send_pair(CMAX, 0, CMIN, 0, 0, CMAX, 0, CMIN);
      send_pair(CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX);
      send_pair(-1, -1, -1, -1, CMIN, CMIN, CMAX, CMAX);
      send_pair(0, 0, CMAX, 1, CMAX, 0, 0, 1);
      send_pair(0, 0, 4, 4, 1, 0, 5, 4);
      send_pair(0, 0, 4, 4, 2, 2, 6, 6);
      send_pair(0, 0, 2, 2, 3, 3, 5, 5);
      send_pair(0, 0, 2, 2, 2, 2, 5, 5);
      send_pair(0, -5, 0, -3, 0, -2, 0, 4);
      send_pair(-7, 2, -4, 2, -3, 2, 1, 2);
      send_pair(3, 0, 3, 0, 0, 0, 6, 0);
      send_pair(3, 1, 3, 1, 0, 0, 6, 0);
      send_pair(1, 1, 1, 1, 2, 2, 2, 2);
      send_pair(0, 0, 4, 0, 2, 0, 2, 5);
      send_pair(0, 0, 4, 0, 2, 1, 2, 5);
      send_pair(0, 0, 4, 0, 5, -1, 5, 1);
      send_pair(-3, -3, 3, 3, -3, 3, 3, -3);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain_results();
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            foreach (c[i]) c[i] = pick_coord(0);
         end else if (kind <= 4) begin
            foreach (c[i]) c[i] = pick_coord(1);
         end else if (kind <= 7) begin
            // points on one line; shifted off it for a parallel pair
            base_x = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            base_y = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            dir_x = int'($urandom_range(0, 6)) - 3;
            dir_y = int'($urandom_range(0, 6)) - 3;
            off_x = (kind == 7) ? int'($urandom_range(0, 4)) - 2 : 0;
            off_y = (kind == 7) ? int'($urandom_range(0, 4)) - 2 : 0;
            for (int p = 0; p < 4; p++) begin
               k = int'($urandom_range(0, 8)) - 4;
               c[2*p]   = base_x + k * dir_x + ((p >= 2) ? off_x : 0);
               c[2*p+1] = base_y + k * dir_y + ((p >= 2) ? off_y : 0);
            end
         end else if (kind == 8) begin
            foreach (c[i]) c[i] = pick_coord(2);
         end else begin
            foreach (c[i]) c[i] = pick_coord($urandom_range(0, 2));
         end
         send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/sis_pkg.sv
design/sis_cross.sv
design/segment_intersection_test.sv
tb/segment_intersection_checker.sv
tb/segment_intersection_test_test.sv
